// ===== design/vfbw_pkg.sv =====
// ----------------------------------------------------------------------------
// vfbw_pkg
// Shared types and constants of the video fade to black or white block.
// ----------------------------------------------------------------------------
`default_nettype none

package vfbw_pkg;

   localparam int FACTOR_FRACTION_BITS = 24;
   localparam int QUEUE_DEPTH          = 4;
   localparam int FRAME_WIDTH          = 18;
   localparam int CSR_INDEX_WIDTH      = 3;

   localparam logic [FRAME_WIDTH-1:0] FRAME_MAX = {FRAME_WIDTH{1'b1}};

   localparam logic [7:0] LUMA_WHITE = 8'd235;
   localparam logic [7:0] LUMA_BLACK = 8'd16;
   localparam logic [7:0] CHROMA_MID = 8'd128;

   localparam logic [1:0] PLANE_LUMA = 2'd0;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_WHITE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FADE_IN      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_FRAME  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DURATION     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_FACTOR = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FACTOR_STEP  = 3'd5;

   typedef struct packed {
      logic [7:0] sample;
      logic [1:0] plane;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_sample;
      logic [1:0] out_plane;
      logic       out_frame_end;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/vfbw_front.sv =====
// ----------------------------------------------------------------------------
// vfbw_front
// Config registers, frame counter and factor sequence. Classifies each beat
// into a target value and a blend factor (0 replaces, one passes).
// ----------------------------------------------------------------------------
`default_nettype none

module vfbw_front #(
   parameter int FACTOR_FRACTION_BITS = vfbw_pkg::FACTOR_FRACTION_BITS
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          csr_write_en,
   input  wire  [vfbw_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  wire  [FACTOR_FRACTION_BITS+3:0]              csr_wdata,
   input  wire                                          req_valid,
   output logic                                         req_ready,
   input  wire  vfbw_pkg::req_type                      req_item,
   output logic                                         job_valid,
   input  wire                                          job_ready,
   output vfbw_pkg::req_type                            job_item,
   output logic [7:0]                                   job_target,
   output logic [FACTOR_FRACTION_BITS:0]                job_factor
);

   localparam int F  = FACTOR_FRACTION_BITS;
   localparam int FW = vfbw_pkg::FRAME_WIDTH;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   logic          target_white_ff;
   logic          fade_in_ff;
   logic [15:0]   start_frame_ff;
   logic [15:0]   duration_ff;
   logic [F:0]    first_factor_ff;
   logic [F+3:0]  factor_step_ff;

   logic [FW-1:0] frame_index_ff;
   logic [FW-1:0] frame_index_in;
   logic [F:0]    blend_factor_ff;
   logic [F:0]    blend_factor_in;

   logic          accept;
   logic [16:0]   fade_end;
   logic          before_fade;
   logic          in_fade;
   logic [F:0]    first_capped;
   logic [F:0]    cur_factor;
   logic [2*F+4:0] step_prod;
   logic [F+4:0]  next_raw;
   logic [F:0]    next_factor;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_white_ff <= 1'b0;
         fade_in_ff      <= 1'b0;
         start_frame_ff  <= 16'd0;
         duration_ff     <= 16'd1;
         first_factor_ff <= ONE;
         factor_step_ff  <= {3'd0, ONE};
      end else if (csr_write_en) begin
         case (csr_index)
            vfbw_pkg::CSR_TARGET_WHITE: target_white_ff <= csr_wdata[0];
            vfbw_pkg::CSR_FADE_IN:      fade_in_ff      <= csr_wdata[0];
            vfbw_pkg::CSR_START_FRAME:  start_frame_ff  <= csr_wdata[15:0];
            vfbw_pkg::CSR_DURATION:     duration_ff     <= csr_wdata[15:0];
            vfbw_pkg::CSR_FIRST_FACTOR: first_factor_ff <= csr_wdata[F:0];
            vfbw_pkg::CSR_FACTOR_STEP:  factor_step_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept    = req_valid & job_ready;
   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign job_item  = req_item;

   assign fade_end    = {1'b0, start_frame_ff} + {1'b0, duration_ff};
   assign before_fade = frame_index_ff < {2'b00, start_frame_ff};
   assign in_fade     = !before_fade && (frame_index_ff < {1'b0, fade_end});

   assign first_capped = (first_factor_ff > ONE) ? ONE : first_factor_ff;
   assign cur_factor   = (frame_index_ff == {2'b00, start_frame_ff}) ?
                         first_capped : blend_factor_ff;

   assign step_prod   = {{(F+4){1'b0}}, cur_factor} * {{(F+1){1'b0}}, factor_step_ff};
   assign next_raw    = step_prod[2*F+4:F];
   assign next_factor = (next_raw > {4'd0, ONE}) ? ONE : next_raw[F:0];

   always_comb begin
      if (req_item.plane == vfbw_pkg::PLANE_LUMA) begin
         job_target = target_white_ff ? vfbw_pkg::LUMA_WHITE : vfbw_pkg::LUMA_BLACK;
      end else begin
         job_target = vfbw_pkg::CHROMA_MID;
      end
      if (before_fade) begin
         job_factor = fade_in_ff ? '0 : ONE;
      end else if (in_fade) begin
         job_factor = cur_factor;
      end else begin
         job_factor = fade_in_ff ? ONE : '0;
      end
   end

   always_comb begin
      frame_index_in  = frame_index_ff;
      blend_factor_in = blend_factor_ff;
      if (accept && req_item.frame_end) begin
         if (frame_index_ff != vfbw_pkg::FRAME_MAX) begin
            frame_index_in = frame_index_ff + 1'b1;
         end
         if (in_fade) begin
            blend_factor_in = next_factor;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_index_ff  <= '0;
         blend_factor_ff <= '0;
      end else begin
         frame_index_ff  <= frame_index_in;
         blend_factor_ff <= blend_factor_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/vfbw_queue.sv =====
// ----------------------------------------------------------------------------
// vfbw_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module vfbw_queue #(
   parameter int DATA_WIDTH = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push_valid,
   output logic                  push_ready,
   input  wire  [DATA_WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire                   pop_ready,
   output logic [DATA_WIDTH-1:0] pop_data
);

   localparam int DEPTH = vfbw_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff;
   logic [PW-1:0]         rd_ptr_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_data   = data_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/vfbw_back.sv =====
// ----------------------------------------------------------------------------
// vfbw_back
// Blend datapath: out = target + floor(f * (sample - target) / one).
// One multiply stage, then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vfbw_back #(
   parameter int FACTOR_FRACTION_BITS = vfbw_pkg::FACTOR_FRACTION_BITS
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            job_valid,
   output logic                           job_ready,
   input  wire  vfbw_pkg::req_type        job_item,
   input  wire  [7:0]                     job_target,
   input  wire  [FACTOR_FRACTION_BITS:0]  job_factor,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output vfbw_pkg::rsp_type              rsp_item
);

   localparam int F  = FACTOR_FRACTION_BITS;
   localparam int PW = F + 11;

   logic                  mid_valid_ff;
   logic signed [PW-1:0]  prod_ff;
   logic [7:0]            target_ff;
   logic [1:0]            plane_ff;
   logic                  frame_end_ff;
   logic                  rsp_valid_ff;
   vfbw_pkg::rsp_type     rsp_item_ff;

   logic                  adv_out;
   logic                  adv_mid;
   logic signed [8:0]     diff;
   logic signed [PW-1:0]  prod_in;
   logic signed [PW-1:0]  scaled;
   logic [8:0]            sum;

   assign adv_out   = !rsp_valid_ff || rsp_ready;
   assign adv_mid   = !mid_valid_ff || adv_out;
   assign job_ready = adv_mid;

   assign diff    = $signed({1'b0, job_item.sample}) - $signed({1'b0, job_target});
   assign prod_in = $signed({1'b0, job_factor}) * diff;
   assign scaled  = prod_ff >>> F;
   assign sum     = {1'b0, target_ff} + scaled[8:0];

   always_ff @(posedge clock) begin
      if (adv_mid) begin
         prod_ff      <= prod_in;
         target_ff    <= job_target;
         plane_ff     <= job_item.plane;
         frame_end_ff <= job_item.frame_end;
      end
      if (adv_out) begin
         rsp_item_ff.out_sample    <= sum[7:0];
         rsp_item_ff.out_plane     <= plane_ff;
         rsp_item_ff.out_frame_end <= frame_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv_mid) begin
            mid_valid_ff <= job_valid;
         end
         if (adv_out) begin
            rsp_valid_ff <= mid_valid_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

// ===== design/video_fade_black_white.sv =====
// ----------------------------------------------------------------------------
// video_fade_black_white
// Fade to or from black or white on a YUV 4:2:0 sample stream.
//
// req_* carries one sample beat (sample, plane, frame_end); rsp_* returns
// one beat per request, in order, with plane and frame_end passed through.
// Both use valid/ready; a beat moves when valid and ready are both high.
// csr_* is a write-only register port (write enable, index, data); write it
// only while the stream is idle.
// Throughput: one beat per cycle while the receiver does not stall. A beat
// is written into the queue when accepted, then passes the multiply stage and
// the output register before response valid.
// The front part classifies each beat and steps the per-frame factor with
// one multiply per frame end; the back part blends with one multiply.
// A 4-deep queue between them lets the input keep flowing while the
// receiver stalls; req_ready drops only when that queue is full.
// Reset clears the frame counter, the factor and the registers to defaults
// and empties the queue and pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module video_fade_black_white #(
   parameter int FACTOR_FRACTION_BITS = vfbw_pkg::FACTOR_FRACTION_BITS
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write_en,
   input  wire  [vfbw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [FACTOR_FRACTION_BITS+3:0]       csr_wdata,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  vfbw_pkg::req_type               req_item,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output vfbw_pkg::rsp_type                     rsp_item
);

   localparam int F  = FACTOR_FRACTION_BITS;
   localparam int IW = $bits(vfbw_pkg::req_type);
   localparam int JW = IW + 8 + F + 1;

   logic              front_valid;
   logic              front_ready;
   vfbw_pkg::req_type front_item;
   logic [7:0]        front_target;
   logic [F:0]        front_factor;

   logic              back_valid;
   logic              back_ready;
   logic [JW-1:0]     back_data;
   vfbw_pkg::req_type back_item;
   logic [7:0]        back_target;
   logic [F:0]        back_factor;

   vfbw_front #(
      .FACTOR_FRACTION_BITS(F)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_item     (req_item),
      .job_valid    (front_valid),
      .job_ready    (front_ready),
      .job_item     (front_item),
      .job_target   (front_target),
      .job_factor   (front_factor)
   );

   vfbw_queue #(
      .DATA_WIDTH(JW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  ({front_item, front_target, front_factor}),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_data)
   );

   assign back_item   = back_data[JW-1 -: IW];
   assign back_target = back_data[F+8 -: 8];
   assign back_factor = back_data[F:0];

   vfbw_back #(
      .FACTOR_FRACTION_BITS(F)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (back_valid),
      .job_ready  (back_ready),
      .job_item   (back_item),
      .job_target (back_target),
      .job_factor (back_factor),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire
